// ===== src/length_prefix_to_start_code_core_defines.svh =====
// Assertion macros shared by the converter RTL.
`ifndef LENGTH_PREFIX_TO_START_CODE_CORE_DEFINES_SVH
`define LENGTH_PREFIX_TO_START_CODE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LPSC_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LPSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/lpsc_pkg.sv =====
// Types and constants of the length-prefix to start-code converter.
package lpsc_pkg;

  localparam int unsigned BufLenW = 25;
  localparam int unsigned AccW    = 32;

  // Largest buffer the converter honors; longer lengths are clamped.
  localparam logic [32:0] MaxBufferBytes = 33'd16777216;

  localparam logic [7:0] NalTypeMask = 8'h1F;
  localparam logic [7:0] NalTypeIdr  = 8'h05;

  localparam logic [0:3][7:0] StartCode = {8'h00, 8'h00, 8'h00, 8'h01};

  localparam int unsigned CmdFifoDepth = 4;
  localparam int unsigned CmdPtrW      = $clog2(CmdFifoDepth);
  localparam int unsigned CmdCntW      = $clog2(CmdFifoDepth + 1);

  typedef enum logic [1:0] {
    PH_LENGTH  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_DISCARD = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,  // expands to the four start-code bytes
    CMD_DATA  = 2'd1,  // one payload byte
    CMD_QUIET = 2'd2   // end marker with no data
  } cmd_kind_e;

  typedef struct packed {
    logic [7:0]         data_byte;
    logic [BufLenW-1:0] buffer_length;
    logic               first_of_buffer;
  } in_word_t;

  typedef struct packed {
    logic [7:0]         out_byte;
    logic               byte_valid;
    logic               end_of_buffer;
    logic               is_idr;
    logic [BufLenW-1:0] bytes_written;
  } out_word_t;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [7:0]         data;
    logic               eob;
    logic               idr;
    logic [BufLenW-1:0] written;
  } cmd_t;

endpackage

// ===== src/lpsc_stream_if.sv =====
// Valid/ready stream channel carrying one payload word.
interface lpsc_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/lpsc_front.sv =====
// Front end: takes input bytes, tracks the buffer parse and issues commands.
module lpsc_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  lpsc_pkg::in_word_t in_word_i,
  input  logic             q_full_i,
  output logic             push_o,
  output lpsc_pkg::cmd_t   cmd_o
);
  import lpsc_pkg::*;

  logic [BufLenW-1:0] offset_q, offset_d, cur_offset;
  phase_e             phase_q, phase_d, cur_phase;
  logic [AccW-1:0]    acc_q, acc_d, cur_acc, acc_new;
  logic [1:0]         pfx_q, pfx_d, cur_pfx, pfx_new;
  logic [BufLenW-1:0] pl_q, pl_d, cur_pl, pl_dec;
  logic               idr_q, idr_d, cur_idr;
  logic [BufLenW-1:0] wr_q, wr_d, cur_wr;

  logic [BufLenW-1:0] len;
  logic               first, accept, active, last;
  logic               emit_start, emit_data;
  logic               short_tail, too_long;
  logic [32:0]        unit_end;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign first      = in_word_i.first_of_buffer;

  // first_of_buffer clears the per-buffer state before this byte is parsed
  assign cur_offset = first ? '0 : offset_q;
  assign cur_phase  = first ? PH_LENGTH : phase_q;
  assign cur_acc    = first ? '0 : acc_q;
  assign cur_pfx    = first ? '0 : pfx_q;
  assign cur_pl     = first ? '0 : pl_q;
  assign cur_idr    = first ? 1'b0 : idr_q;
  assign cur_wr     = first ? '0 : wr_q;

  always_comb begin
    len = in_word_i.buffer_length;
    if (len == '0) begin
      len = BufLenW'(1);
    end
    if ({8'b0, len} > MaxBufferBytes) begin
      len = MaxBufferBytes[BufLenW-1:0];
    end
  end

  assign active     = cur_offset < len;
  assign last       = ({1'b0, cur_offset} + 26'd1) == {1'b0, len};
  assign short_tail = ({1'b0, cur_offset} + 26'd4) > {1'b0, len};
  assign acc_new    = {cur_acc[AccW-9:0], in_word_i.data_byte};
  assign pfx_new    = cur_pfx + 2'd1;
  assign unit_end   = {8'b0, cur_offset} + 33'd1 + {1'b0, acc_new};
  assign too_long   = unit_end > {8'b0, len};
  assign pl_dec     = (cur_pl != '0) ? cur_pl - BufLenW'(1) : '0;

  always_comb begin
    offset_d   = cur_offset;
    phase_d    = cur_phase;
    acc_d      = cur_acc;
    pfx_d      = cur_pfx;
    pl_d       = cur_pl;
    idr_d      = cur_idr;
    wr_d       = cur_wr;
    emit_start = 1'b0;
    emit_data  = 1'b0;
    if (active) begin
      offset_d = cur_offset + BufLenW'(1);
      case (cur_phase)
        PH_LENGTH: begin
          if (cur_pfx == 2'd0 && short_tail) begin
            phase_d = PH_DISCARD;
          end else begin
            acc_d = acc_new;
            pfx_d = pfx_new;
            if (pfx_new == 2'd0) begin
              if (acc_new == '0 || too_long) begin
                phase_d = PH_DISCARD;
              end else begin
                emit_start = 1'b1;
                wr_d       = cur_wr + BufLenW'(4);
                pl_d       = acc_new[BufLenW-1:0];
                phase_d    = PH_PAYLOAD;
              end
            end
          end
        end
        PH_PAYLOAD: begin
          if ({7'b0, cur_pl} == cur_acc
              && (in_word_i.data_byte & NalTypeMask) == NalTypeIdr) begin
            idr_d = 1'b1;
          end
          emit_data = 1'b1;
          wr_d      = cur_wr + BufLenW'(1);
          pl_d      = pl_dec;
          if (pl_dec == '0) begin
            phase_d = PH_LENGTH;
            acc_d   = '0;
            pfx_d   = '0;
          end
        end
        default: begin
          phase_d = PH_DISCARD;
        end
      endcase
    end
  end

  always_comb begin
    push_o      = accept && active && (emit_start || emit_data || last);
    cmd_o.kind  = emit_start ? CMD_START : (emit_data ? CMD_DATA : CMD_QUIET);
    cmd_o.data  = in_word_i.data_byte;
    cmd_o.eob   = last;
    cmd_o.idr   = idr_d;
    cmd_o.written = wr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      phase_q  <= PH_LENGTH;
      acc_q    <= '0;
      pfx_q    <= '0;
      pl_q     <= '0;
      idr_q    <= 1'b0;
      wr_q     <= '0;
    end else if (accept) begin
      offset_q <= offset_d;
      phase_q  <= phase_d;
      acc_q    <= acc_d;
      pfx_q    <= pfx_d;
      pl_q     <= pl_d;
      idr_q    <= idr_d;
      wr_q     <= wr_d;
    end
  end

endmodule

// ===== src/lpsc_fifo.sv =====
// Short command queue between the front and back ends.
module lpsc_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lpsc_pkg::cmd_t push_cmd_i,
  input  logic           pop_i,
  output lpsc_pkg::cmd_t head_o,
  output logic           full_o,
  output logic           empty_o
);
  import lpsc_pkg::*;

  cmd_t               mem_q [CmdFifoDepth];
  logic [CmdPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CmdCntW-1:0] count_q;
  logic               do_push, do_pop;

  assign full_o  = count_q == CmdCntW'(CmdFifoDepth);
  assign empty_o = count_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  function automatic logic [CmdPtrW-1:0] ptr_inc(input logic [CmdPtrW-1:0] p);
    ptr_inc = (p == CmdPtrW'(CmdFifoDepth - 1)) ? '0 : p + CmdPtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + CmdCntW'(1);
        2'b01:   count_q <= count_q - CmdCntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== src/lpsc_back.sv =====
// Back end: expands commands into output words behind an output register.
module lpsc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lpsc_pkg::cmd_t      head_i,
  input  logic                empty_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lpsc_pkg::out_word_t out_word_o
);
  import lpsc_pkg::*;

  logic [1:0] beat_q;
  logic       valid_q;
  out_word_t  word_q, word_d;
  logic       head_last, load;

  assign load        = !empty_i && (!valid_q || out_ready_i);
  assign head_last   = (head_i.kind != CMD_START) || (beat_q == 2'd3);
  assign pop_o       = load && head_last;
  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

  always_comb begin
    word_d.out_byte      = 8'h00;
    word_d.byte_valid    = 1'b1;
    case (head_i.kind)
      CMD_START: word_d.out_byte = StartCode[beat_q];
      CMD_DATA:  word_d.out_byte = head_i.data;
      default:   word_d.byte_valid = 1'b0;
    endcase
    // buffer summary rides only on the final word of the command
    word_d.end_of_buffer = head_last && head_i.eob;
    word_d.is_idr        = head_last && head_i.eob && head_i.idr;
    word_d.bytes_written = (head_last && head_i.eob) ? head_i.written : '0;
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= word_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      beat_q  <= '0;
    end else if (load) begin
      valid_q <= 1'b1;
      beat_q  <= head_last ? 2'd0 : beat_q + 2'd1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

endmodule

// ===== src/length_prefix_to_start_code_core.sv =====
// Length-prefix to start-code converter, top level.
// Input channel in_i carries one byte of a length-prefixed H.264 buffer per
// word, with the buffer's total length and a first-of-buffer flag. Output
// channel out_o carries converted words: start-code or payload bytes, and on
// the buffer's last word the end flag, the IDR flag and the bytes written.
// Each 4-byte length prefix becomes 00 00 00 01; payload bytes pass through;
// zero or overlong lengths and short tails are dropped.
// Throughput: one input word per cycle sustained while the receiver is ready.
// A prefix's four input words give four output words, so the rate is set by
// the single output register, one word per cycle while out_o is ready.
// The four-entry queue between parser and output stage absorbs a start code.
// Path: the command of a taken input word enters the command queue, then the
// output register, from which it leaves once the receiver is ready, when
// nothing is queued ahead of it.
// Reset (rst_ni low, asynchronous) clears the parse state, empties the queue
// and drops the output word; the next buffer must start with first_of_buffer.
// When the receiver stalls, the output word holds, the queue fills and in_i
// ready drops once the queue is full; no word is lost.
`include "length_prefix_to_start_code_core_defines.svh"

module length_prefix_to_start_code_core (
  input logic          clk_i,
  input logic          rst_ni,
  lpsc_stream_if.sink   in_i,
  lpsc_stream_if.source out_o
);
  import lpsc_pkg::*;

  cmd_t push_cmd, head;
  logic push, pop, q_full, q_empty;

  // parser: one input byte per cycle while the queue is not full, at most one command per byte
  lpsc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .in_word_i  (in_i.payload),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  lpsc_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head),
    .full_o     (q_full),
    .empty_o    (q_empty)
  );

  // output stage: a start-code command gives four output words, others one
  lpsc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_word_o  (out_o.payload)
  );

  `LPSC_ASSERT_IMPLIES(a_no_push_when_full, push, !q_full, "command pushed into full queue")
  `LPSC_ASSERT_IMPLIES(a_idr_only_at_end,
    out_o.valid && out_o.payload.is_idr, out_o.payload.end_of_buffer,
    "IDR flag on a word that does not end the buffer")
  `LPSC_ASSERT_IMPLIES(a_quiet_word_is_end,
    out_o.valid && !out_o.payload.byte_valid,
    out_o.payload.end_of_buffer && out_o.payload.out_byte == 8'h00,
    "empty word that is not a clean end marker")
  `LPSC_ASSERT_NEXT(a_idle_latency,
    push && q_empty && !out_o.valid, ##1 out_o.valid,
    "command did not reach the output in two cycles")

endmodule
